@@ sv/mpd_pkg.sv @@
// Shared types and constants for the Morse press decoder.
// Holds the register indexes, field widths and the pattern-to-character lookup function.
// No dependencies.
package mpd_pkg;

   localparam int unsigned TICK_W = 16;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned CODE_W = 7;
   localparam int unsigned HELD_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DOT_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_MAX = 2'd2;

   localparam logic [TICK_W-1:0] DOT_MIN_RESET = 16'd233;
   localparam logic [TICK_W-1:0] DASH_MIN_RESET = 16'd1562;
   localparam logic [TICK_W-1:0] PRESS_MAX_RESET = 16'd24992;

   // Codes of the symbol_kind field.
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DOT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DASH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

   // Item modes carried on tuser.
   localparam logic MODE_PRESS = 1'b0;
   localparam logic MODE_GAP = 1'b1;

   // Only patterns of up to five symbols have a character.
   localparam int unsigned LKP_BITS = 5;
   localparam int unsigned LKP_LEN_W = 3;

   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] code;
   } lkp_word_type;

   // Lookup ROM contents: address is {length, pattern}, pattern bit i set for a dash at
   // position i. Addresses without a character return a miss.
   function automatic lkp_word_type mpd_lookup(input logic [LKP_LEN_W-1:0] len,
                                               input logic [LKP_BITS-1:0] bits);
      lkp_word_type w;
      w.hit = 1'b1;
      case ({len, bits})
         {3'd2, 5'd2}:  w.code = 7'h41; // A
         {3'd4, 5'd1}:  w.code = 7'h42; // B
         {3'd4, 5'd5}:  w.code = 7'h43; // C
         {3'd3, 5'd1}:  w.code = 7'h44; // D
         {3'd1, 5'd0}:  w.code = 7'h45; // E
         {3'd4, 5'd4}:  w.code = 7'h46; // F
         {3'd3, 5'd3}:  w.code = 7'h47; // G
         {3'd4, 5'd0}:  w.code = 7'h48; // H
         {3'd2, 5'd0}:  w.code = 7'h49; // I
         {3'd4, 5'd14}: w.code = 7'h4A; // J
         {3'd3, 5'd5}:  w.code = 7'h4B; // K
         {3'd4, 5'd2}:  w.code = 7'h4C; // L
         {3'd2, 5'd3}:  w.code = 7'h4D; // M
         {3'd2, 5'd1}:  w.code = 7'h4E; // N
         {3'd3, 5'd7}:  w.code = 7'h4F; // O
         {3'd4, 5'd6}:  w.code = 7'h50; // P
         {3'd4, 5'd11}: w.code = 7'h51; // Q
         {3'd3, 5'd2}:  w.code = 7'h52; // R
         {3'd3, 5'd0}:  w.code = 7'h53; // S
         {3'd1, 5'd1}:  w.code = 7'h54; // T
         {3'd3, 5'd4}:  w.code = 7'h55; // U
         {3'd4, 5'd8}:  w.code = 7'h56; // V
         {3'd3, 5'd6}:  w.code = 7'h57; // W
         {3'd4, 5'd9}:  w.code = 7'h58; // X
         {3'd4, 5'd13}: w.code = 7'h59; // Y
         {3'd4, 5'd3}:  w.code = 7'h5A; // Z
         {3'd5, 5'd30}: w.code = 7'h31; // 1
         {3'd5, 5'd31}: w.code = 7'h30; // 0
         {3'd5, 5'd28}: w.code = 7'h32; // 2
         {3'd5, 5'd24}: w.code = 7'h33; // 3
         {3'd5, 5'd16}: w.code = 7'h34; // 4
         {3'd5, 5'd0}:  w.code = 7'h35; // 5
         {3'd5, 5'd1}:  w.code = 7'h36; // 6
         {3'd5, 5'd3}:  w.code = 7'h37; // 7
         {3'd5, 5'd7}:  w.code = 7'h38; // 8
         {3'd5, 5'd15}: w.code = 7'h39; // 9
         default: begin
            w.hit = 1'b0;
            w.code = '0;
         end
      endcase
      return w;
   endfunction

endpackage

@@ sv/morse_press_decoder_unit.sv @@
// Morse press decoder: turns press durations and letter gaps into ASCII characters.
// Top level; depends on mpd_pkg for codes, widths and the character lookup ROM.
//
// Each req_ item is either a key press (tuser 0, tdata = duration in ticks) or a letter gap
// (tuser 1). Presses strictly between dot_min_ticks and press_max_ticks append a dot or a
// dash; a gap decodes the held pattern and clears it when a character is found. The block
// takes one item per clock and returns exactly one rsp_ item for each, in the next cycle. The
// rate is one item per cycle because the lookup ROM is read every cycle at the address of
// the pattern that the current item leaves behind, so its registered output always matches
// the held pattern when the next gap arrives. A waiting result blocks req_tready only while
// rsp_tready is low. No clearing pass follows reset.
module morse_press_decoder_unit
   import mpd_pkg::*;
#(
   parameter int unsigned MAX_SYMBOLS = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TICK_W-1:0]    req_tdata,  // [15:0] press_ticks
   input  logic                 req_tuser,  // [0] mode
   // Result channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // [1:0] symbol_kind, [2] char_valid,
                                            // [9:3] char_code, [12:10] held_count, [15:13] 0
   // Configuration write port.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SYMBOLS);
   localparam logic [CNT_W-1:0] CNT_LKP_MAX = CNT_W'(LKP_BITS);
   localparam logic [CNT_W-1:0] CNT_HELD_MAX = CNT_W'((1 << HELD_W) - 1);

   logic [TICK_W-1:0]      dot_min_ff, dash_min_ff, press_max_ff;
   logic [MAX_SYMBOLS-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   lkp_word_type           rom_ff, rom_in;

   logic                   out_valid_ff;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic                   char_valid_ff, char_valid_in;
   logic [CODE_W-1:0]      char_code_ff, char_code_in;
   logic [HELD_W-1:0]      held_ff, held_in;

   logic                   accept;
   logic                   in_window, is_dash;
   logic [LKP_BITS-1:0]    lkp_bits;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   assign in_window = (req_tdata > dot_min_ff) && (req_tdata < press_max_ff);
   assign is_dash = req_tdata >= dash_min_ff;

   always_comb begin
      bits_in = bits_ff;
      count_in = count_ff;
      kind_in = KIND_NONE;
      char_valid_in = 1'b0;
      char_code_in = '0;
      if (accept) begin
         if (req_tuser == MODE_PRESS) begin
            if (in_window) begin
               if (count_ff >= CNT_MAX) begin
                  bits_in = '0;
                  count_in = '0;
                  kind_in = KIND_OVERFLOW;
               end else begin
                  for (int i = 0; i < MAX_SYMBOLS; i++) begin
                     if (count_ff == CNT_W'(i)) begin
                        bits_in[i] = is_dash;
                     end
                  end
                  count_in = count_ff + 1'b1;
                  kind_in = is_dash ? KIND_DASH : KIND_DOT;
               end
            end
         end else if (rom_ff.hit) begin
            // The registered ROM word belongs to the pattern held right now.
            bits_in = '0;
            count_in = '0;
            char_valid_in = 1'b1;
            char_code_in = rom_ff.code;
         end
      end
      held_in = (count_in > CNT_HELD_MAX) ? HELD_W'(CNT_HELD_MAX) : HELD_W'(count_in);
   end

   // ROM address comes from the pattern this cycle leaves, masked to its length.
   always_comb begin
      for (int i = 0; i < LKP_BITS; i++) begin
         lkp_bits[i] = bits_in[i] && (CNT_W'(i) < count_in);
      end
      if (count_in <= CNT_LKP_MAX) begin
         rom_in = mpd_lookup(LKP_LEN_W'(count_in), lkp_bits);
      end else begin
         rom_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_min_ff <= DOT_MIN_RESET;
         dash_min_ff <= DASH_MIN_RESET;
         press_max_ff <= PRESS_MAX_RESET;
         bits_ff <= '0;
         count_ff <= '0;
         rom_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DOT_MIN:   dot_min_ff <= csr_wdata;
               CSR_DASH_MIN:  dash_min_ff <= csr_wdata;
               CSR_PRESS_MAX: press_max_ff <= csr_wdata;
               default: ;
            endcase
         end
         bits_ff <= bits_in;
         count_ff <= count_in;
         rom_ff <= rom_in;
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
         char_valid_ff <= char_valid_in;
         char_code_ff <= char_code_in;
         held_ff <= held_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {3'b000, held_ff, char_code_ff, char_valid_ff, kind_ff};

endmodule

@@ tb/sv/morse_press_decoder_unit_test.sv @@
// Self-checking testbench for morse_press_decoder_unit: drives press and gap items,
// predicts each result with its own Morse decoder and compares every field of rsp_tdata.
// Depends on mpd_pkg and the morse_press_decoder_unit RTL.
`timescale 1ns / 100ps

module morse_press_decoder_unit_test;
   import mpd_pkg::*;

   localparam int unsigned HOLD_LIMIT = 7;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [HELD_W-1:0] held;
   } decode_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [TICK_W-1:0] req_tdata = '0;
   logic req_tuser = MODE_PRESS;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DOT_MIN;
   logic [TICK_W-1:0] csr_wdata = '0;

   // Predictor copy of the limits and of the held pattern.
   logic [TICK_W-1:0] lim_dot_min = DOT_MIN_RESET;
   logic [TICK_W-1:0] lim_dash_min = DASH_MIN_RESET;
   logic [TICK_W-1:0] lim_press_max = PRESS_MAX_RESET;
   logic [7:0] held_bits = '0;
   int unsigned held_cnt = 0;

   decode_result_type expected_results[$];
   int error_count = 0;
   int stall_cycles = 0;
   logic steady_flow = 1'b0;

   morse_press_decoder_unit #(
      .MAX_SYMBOLS(HOLD_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Dots and dashes of one character, first symbol leftmost.
   function automatic string char_pattern(input byte c);
      case (c)
         "A": return ".-";
         "B": return "-...";
         "C": return "-.-.";
         "D": return "-..";
         "E": return ".";
         "F": return "..-.";
         "G": return "--.";
         "H": return "....";
         "I": return "..";
         "J": return ".---";
         "K": return "-.-";
         "L": return ".-..";
         "M": return "--";
         "N": return "-.";
         "O": return "---";
         "P": return ".--.";
         "Q": return "--.-";
         "R": return ".-.";
         "S": return "...";
         "T": return "-";
         "U": return "..-";
         "V": return "...-";
         "W": return ".--";
         "X": return "-..-";
         "Y": return "-.--";
         "Z": return "--..";
         "0": return "-----";
         "1": return ".----";
         "2": return "..---";
         "3": return "...--";
         "4": return "....-";
         "5": return ".....";
         "6": return "-....";
         "7": return "--...";
         "8": return "---..";
         "9": return "----.";
         default: return "";
      endcase
   endfunction

   function automatic byte char_at(input int idx);
      return (idx < 26) ? byte'("A" + idx) : byte'("0" + idx - 26);
   endfunction

   // Works out the result of one accepted item and advances the held pattern.
   function automatic decode_result_type predict_decode(input logic mode,
                                                        input logic [TICK_W-1:0] ticks);
      decode_result_type r;
      string pat;
      logic is_dash;
      int c;
      int i;
      byte ch;
      r = '0;
      pat = "";
      if (mode == MODE_PRESS) begin
         if (ticks > lim_dot_min && ticks < lim_press_max) begin
            is_dash = (ticks >= lim_dash_min);
            if (held_cnt >= HOLD_LIMIT) begin
               held_bits = '0;
               held_cnt = 0;
               r.kind = KIND_OVERFLOW;
            end else begin
               held_bits[held_cnt] = is_dash;
               held_cnt++;
               r.kind = is_dash ? KIND_DASH : KIND_DOT;
            end
         end
      end else begin
         for (i = 0; i < int'(held_cnt); i++) begin
            if (held_bits[i]) pat = {pat, "-"};
            else pat = {pat, "."};
         end
         // An empty pattern matches nothing, and an unmatched pattern stays held.
         for (c = 0; c < 36 && !r.valid; c++) begin
            ch = char_at(c);
            if (char_pattern(ch) == pat) begin
               r.valid = 1'b1;
               r.code = ch[CODE_W-1:0];
               held_bits = '0;
               held_cnt = 0;
            end
         end
      end
      r.held = (held_cnt > 7) ? 3'd7 : held_cnt[HELD_W-1:0];
      return r;
   endfunction

   // A duration that lands on the wanted symbol under the current limits, if any does.
   function automatic logic [TICK_W-1:0] pick_ticks(input logic want_dash);
      int lo;
      int hi;
      lo = int'(lim_dot_min) + 1;
      hi = int'(lim_press_max) - 1;
      if (want_dash) begin
         if (int'(lim_dash_min) > lo) lo = int'(lim_dash_min);
      end else begin
         if (int'(lim_dash_min) - 1 < hi) hi = int'(lim_dash_min) - 1;
      end
      if (lo <= hi) return TICK_W'($urandom_range(hi, lo));
      return TICK_W'($urandom);
   endfunction

   task automatic send_item(input logic mode, input logic [TICK_W-1:0] ticks);
      while (!steady_flow && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         req_tdata <= TICK_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= ticks;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_decode(mode, ticks));
   endtask

   // Lowers valid and waits until every result is back and the block has settled.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_limits(input logic [TICK_W-1:0] dot_min,
                                 input logic [TICK_W-1:0] dash_min,
                                 input logic [TICK_W-1:0] press_max,
                                 input logic poke_unused);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= CSR_DOT_MIN;
      csr_wdata <= dot_min;
      @(posedge clock);
      csr_index <= CSR_DASH_MIN;
      csr_wdata <= dash_min;
      @(posedge clock);
      csr_index <= CSR_PRESS_MAX;
      csr_wdata <= press_max;
      @(posedge clock);
      if (poke_unused) begin
         // The unused index must leave all three limits alone.
         csr_index <= CSR_UNUSED;
         csr_wdata <= TICK_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      lim_dot_min = dot_min;
      lim_dash_min = dash_min;
      lim_press_max = press_max;
   endtask

   task automatic run_traffic(input int n_items);
      int sent;
      int r;
      int k;
      string pat;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 72) begin
            // Mostly start a letter from an empty buffer: flush leftovers by overflow.
            if (held_cnt != 0 && $urandom_range(99) < 80) begin
               repeat (HOLD_LIMIT + 1 - held_cnt) begin
                  send_item(MODE_PRESS, pick_ticks($urandom_range(1)));
                  sent++;
               end
            end
            pat = char_pattern(char_at($urandom_range(35)));
            for (k = 0; k < pat.len(); k++) begin
               if ($urandom_range(99) < 6) begin
                  send_item(MODE_PRESS, TICK_W'($urandom));
                  sent++;
               end
               send_item(MODE_PRESS, pick_ticks(pat[k] == "-"));
               sent++;
            end
            send_item(MODE_GAP, TICK_W'($urandom));
            sent++;
         end else if (r < 84) begin
            send_item(MODE_PRESS, TICK_W'($urandom));
            sent++;
         end else if (r < 91) begin
            send_item(MODE_GAP, TICK_W'($urandom));
            sent++;
         end else begin
            repeat ($urandom_range(9, 6)) begin
               send_item(MODE_PRESS, pick_ticks($urandom_range(1)));
               sent++;
            end
            send_item(MODE_GAP, TICK_W'($urandom));
            sent++;
         end
      end
   endtask

   // Window edges at the reset limits, long patterns, overflow, empty gap and a few letters.
   task automatic test_directed_edges();
      send_item(MODE_PRESS, 16'd0);
      send_item(MODE_PRESS, 16'd233);
      send_item(MODE_PRESS, 16'd234);
      send_item(MODE_PRESS, 16'd1561);
      send_item(MODE_PRESS, 16'd1562);
      send_item(MODE_PRESS, 16'd24991);
      send_item(MODE_PRESS, 16'd24992);
      send_item(MODE_PRESS, 16'hFFFF);
      send_item(MODE_GAP, 16'hFFFF);
      send_item(MODE_PRESS, 16'd5000);
      send_item(MODE_PRESS, 16'd300);
      send_item(MODE_PRESS, 16'd20000);
      send_item(MODE_GAP, 16'd0);
      send_item(MODE_PRESS, 16'd2000);
      send_item(MODE_GAP, 16'h5A5A);
      send_item(MODE_PRESS, 16'd500);
      send_item(MODE_GAP, 16'd0);
      send_item(MODE_PRESS, 16'd3000);
      send_item(MODE_GAP, 16'd0);
      repeat (5) send_item(MODE_PRESS, 16'd8000);
      send_item(MODE_GAP, 16'd0);
   endtask

   task automatic test_reset_limits();
      steady_flow <= 1'b1;
      run_traffic(200);
      steady_flow <= 1'b0;
      run_traffic(300);
   endtask

   task automatic test_widest_window();
      program_limits(16'd0, 16'd1, 16'hFFFF, 1'b1);
      run_traffic(400);
   endtask

   task automatic test_crossed_dash_limit();
      program_limits(16'd100, 16'd50, 16'd5000, 1'b0);
      run_traffic(250);
   endtask

   task automatic test_empty_window();
      program_limits(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
      run_traffic(40);
      program_limits(16'd1000, 16'd2000, 16'd500, 1'b0);
      run_traffic(40);
      program_limits(16'd0, 16'd0, 16'd0, 1'b1);
      run_traffic(40);
   endtask

   task automatic test_random_limits();
      int dot_v;
      int dash_v;
      int max_v;
      repeat (3) begin
         dot_v = $urandom_range(3000);
         dash_v = dot_v + $urandom_range(4000, 1);
         max_v = dash_v + $urandom_range(30000, 1);
         if (max_v > 65535) max_v = 65535;
         program_limits(TICK_W'(dot_v), TICK_W'(dash_v), TICK_W'(max_v), 1'b0);
         run_traffic(200);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 35);
   end

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                  actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      decode_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual 0x%04h", $time,
                     rsp_tdata);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            check_field("symbol_kind", exp_r.kind, rsp_tdata[1:0]);
            check_field("char_valid", exp_r.valid, rsp_tdata[2]);
            check_field("char_code", exp_r.code, rsp_tdata[9:3]);
            check_field("held_count", exp_r.held, rsp_tdata[12:10]);
            check_field("padding", 0, rsp_tdata[15:13]);
         end
      end
   end

   // Ends the run when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_reset_limits();
      test_widest_window();
      test_crossed_dash_limit();
      test_empty_window();
      test_random_limits();
      drain_results();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ morse_press_decoder_unit.f @@
sv/mpd_pkg.sv
sv/morse_press_decoder_unit.sv
tb/sv/morse_press_decoder_unit_test.sv
